/* hw/rtl/fvc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the frustum volume cull block
// no dependencies

package fvc_pkg;

    localparam int PLANE_COUNT   = 6;
    localparam int TABLE_DEPTH   = PLANE_COUNT + 1;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W       = 128;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIST_W        = 68;
    localparam int POINT_COUNT   = 9;

    localparam logic [ADDR_W-1:0] SPHERE_SLOT = ADDR_W'(PLANE_COUNT);
    localparam logic [ADDR_W-1:0] FAR_COUNT   = ADDR_W'(PLANE_COUNT);
    localparam logic [ADDR_W-1:0] NEAR_COUNT  = ADDR_W'(PLANE_COUNT - 1);

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_BOX    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        V_OUTSIDE   = 2'd0,
        V_INTERSECT = 2'd1,
        V_INSIDE    = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REJ_MUL,
        S_REJ_SUM,
        S_REJ_CMP,
        S_SPH_MUL,
        S_SPH_EVAL,
        S_BOX_MN,
        S_BOX_MX,
        S_BOX_POS,
        S_BOX_EVAL
    } t_state;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ENTRY_W-1:0]  wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } t_tab_req;

endpackage

/* hw/rtl/fvc_table.sv */
`timescale 1ns / 1ps
// plane and frustum sphere table, one write and one registered read port
// depends on fvc_pkg

module fvc_table (
    input  logic                        i_clk,
    input  fvc_pkg::t_tab_req           i_req,
    output logic [fvc_pkg::ENTRY_W-1:0] o_rd_data
);
    import fvc_pkg::*;

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* hw/rtl/frustum_volume_cull.sv */
`timescale 1ns / 1ps
// top level: sequencer and three shared multipliers over the plane table
// depends on fvc_pkg and fvc_table

// Loads (cmd 0) and sphere requests (cmd 1) finish in the cycle they are taken.
// A box request runs the sphere reject (S_REJ_MUL, S_REJ_SUM, S_REJ_CMP), then
// per plane the sphere test (S_SPH_MUL, S_SPH_EVAL) and, if that intersects,
// per plane the box test (S_BOX_MN, S_BOX_MX, S_BOX_POS, S_BOX_EVAL), all through
// one registered table read port and three 33x33 multipliers, over five or six planes.
// busy is high for the whole run; the verdict appears on o_verdict with
// o_valid for one cycle and cannot be held off by the receiver.

module frustum_volume_cull #(
    parameter int FRAC_BITS = fvc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_cmd,
    input  logic [2:0]         i_slot,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_aw,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    output logic               o_valid,
    output logic [1:0]         o_verdict,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_data
);
    import fvc_pkg::*;

    t_state r_state, n_state;
    t_tab_req tab_req;
    logic [ENTRY_W-1:0] rd_data;

    logic r_inf;
    logic signed [31:0] r_vx, r_vy, r_vz, r_vr;
    logic signed [31:0] r_mn [3];
    logic signed [31:0] r_mx [3];
    logic signed [31:0] r_pos [3];
    logic signed [32:0] r_rs, n_rs;
    logic signed [DIST_W-1:0] r_sq, n_sq;
    logic signed [65:0] r_p [3];
    logic signed [65:0] r_qmn [3];
    logic signed [65:0] r_qmx [3];
    logic signed [32:0] n_ma [3];
    logic signed [32:0] n_mb [3];
    logic [ADDR_W-1:0] r_i, n_i, r_n, n_n, r_allin, n_allin;
    logic r_valid, n_valid;
    t_verdict r_verdict, n_verdict;
    logic q_cap_mn, q_cap_mx;

    logic signed [31:0] pa, pb, pc, pd;
    logic signed [DIST_W-1:0] pl_dist, adist, rad, nrad, dterm;
    logic signed [DIST_W-1:0] pdist;
    logic signed [65:0] sx, sy, sz;
    logic [POINT_COUNT-1:0] neg;

    assign pa = rd_data[127:96];
    assign pb = rd_data[95:64];
    assign pc = rd_data[63:32];
    assign pd = rd_data[31:0];

    fvc_table u_table (
        .i_clk     (i_clk),
        .i_req     (tab_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_inf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_inf <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_p[k] <= n_ma[k] * n_mb[k];
            if (q_cap_mn) r_qmn[k] <= r_p[k];
            if (q_cap_mx) r_qmx[k] <= r_p[k];
        end
        r_rs      <= n_rs;
        r_sq      <= n_sq;
        r_i       <= n_i;
        r_n       <= n_n;
        r_allin   <= n_allin;
        r_verdict <= n_verdict;
        if (r_state == S_IDLE && i_start) begin
            if (t_cmd'(i_cmd) == CMD_SPHERE) begin
                r_vx <= i_ax;
                r_vy <= i_ay;
                r_vz <= i_az;
                r_vr <= i_aw;
            end
            if (t_cmd'(i_cmd) == CMD_BOX) begin
                r_mn  <= '{i_ax, i_ay, i_az};
                r_mx  <= '{i_bx, i_by, i_bz};
                r_pos <= '{i_px, i_py, i_pz};
            end
        end
    end

    // plane distances from the registered products
    assign dterm   = DIST_W'(pd) <<< FRAC_BITS;
    assign pl_dist = DIST_W'(r_p[0]) + DIST_W'(r_p[1]) + DIST_W'(r_p[2]) + dterm;
    assign adist   = pl_dist[DIST_W-1] ? -pl_dist : pl_dist;
    assign rad     = DIST_W'(r_vr) <<< FRAC_BITS;
    assign nrad    = -rad;

    always_comb begin
        neg = '0;
        for (int j = 0; j < POINT_COUNT - 1; j++) begin
            sx = j[2] ? r_qmn[0] : r_qmx[0];
            sy = j[1] ? r_qmn[1] : r_qmx[1];
            sz = j[0] ? r_qmn[2] : r_qmx[2];
            pdist = DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz) + dterm;
            neg[j] = pdist[DIST_W-1];
        end
        neg[POINT_COUNT-1] = pl_dist[DIST_W-1];
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_verdict = r_verdict;
        n_rs      = r_rs;
        n_sq      = r_sq;
        n_i       = r_i;
        n_n       = r_n;
        n_allin   = r_allin;
        q_cap_mn  = 1'b0;
        q_cap_mx  = 1'b0;
        tab_req   = '0;
        for (int k = 0; k < 3; k++) begin
            n_ma[k] = '0;
            n_mb[k] = '0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    priority case (t_cmd'(i_cmd))
                        CMD_LOAD: begin
                            tab_req.we    = (i_slot <= 3'(SPHERE_SLOT));
                            tab_req.waddr = ADDR_W'(i_slot);
                            tab_req.wdata = {i_ax, i_ay, i_az, i_aw};
                        end
                        CMD_BOX: begin
                            tab_req.re    = 1'b1;
                            tab_req.raddr = SPHERE_SLOT;
                            n_n           = r_inf ? NEAR_COUNT : FAR_COUNT;
                            n_state       = S_REJ_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_REJ_MUL: begin
                n_ma[0] = 33'(pa) - 33'(r_vx);
                n_ma[1] = 33'(pb) - 33'(r_vy);
                n_ma[2] = 33'(pc) - 33'(r_vz);
                n_mb    = n_ma;
                n_rs    = 33'(pd) + 33'(r_vr);
                n_state = S_REJ_SUM;
            end
            S_REJ_SUM: begin
                n_sq    = DIST_W'(r_p[0]) + DIST_W'(r_p[1]) + DIST_W'(r_p[2]);
                n_ma[0] = r_rs;
                n_mb[0] = r_rs;
                n_state = S_REJ_CMP;
            end
            S_REJ_CMP: begin
                if (DIST_W'(r_p[0]) < r_sq) begin
                    n_valid   = 1'b1;
                    n_verdict = V_OUTSIDE;
                    n_state   = S_IDLE;
                end else begin
                    tab_req.re = 1'b1;
                    n_i        = '0;
                    n_state    = S_SPH_MUL;
                end
            end
            S_SPH_MUL: begin
                n_ma    = '{33'(pa), 33'(pb), 33'(pc)};
                n_mb    = '{33'(r_vx), 33'(r_vy), 33'(r_vz)};
                n_state = S_SPH_EVAL;
            end
            S_SPH_EVAL: begin
                if (pl_dist < nrad) begin
                    n_valid   = 1'b1;
                    n_verdict = V_OUTSIDE;
                    n_state   = S_IDLE;
                end else if (adist < rad) begin
                    // sphere straddles a plane, refine with the box
                    tab_req.re = 1'b1;
                    n_i        = '0;
                    n_allin    = '0;
                    n_state    = S_BOX_MN;
                end else if (r_i == r_n - 1'b1) begin
                    n_valid   = 1'b1;
                    n_verdict = V_INSIDE;
                    n_state   = S_IDLE;
                end else begin
                    tab_req.re    = 1'b1;
                    tab_req.raddr = r_i + 1'b1;
                    n_i           = r_i + 1'b1;
                    n_state       = S_SPH_MUL;
                end
            end
            S_BOX_MN: begin
                n_ma    = '{33'(pa), 33'(pb), 33'(pc)};
                n_mb    = '{33'(r_mn[0]), 33'(r_mn[1]), 33'(r_mn[2])};
                n_state = S_BOX_MX;
            end
            S_BOX_MX: begin
                q_cap_mn = 1'b1;
                n_ma     = '{33'(pa), 33'(pb), 33'(pc)};
                n_mb     = '{33'(r_mx[0]), 33'(r_mx[1]), 33'(r_mx[2])};
                n_state  = S_BOX_POS;
            end
            S_BOX_POS: begin
                q_cap_mx = 1'b1;
                n_ma     = '{33'(pa), 33'(pb), 33'(pc)};
                n_mb     = '{33'(r_pos[0]), 33'(r_pos[1]), 33'(r_pos[2])};
                n_state  = S_BOX_EVAL;
            end
            S_BOX_EVAL: begin
                n_allin = r_allin + ADDR_W'(neg == '0);
                if (&neg) begin
                    n_valid   = 1'b1;
                    n_verdict = V_OUTSIDE;
                    n_state   = S_IDLE;
                end else if (r_i == r_n - 1'b1) begin
                    n_valid   = 1'b1;
                    n_verdict = (n_allin == r_n) ? V_INSIDE : V_INTERSECT;
                    n_state   = S_IDLE;
                end else begin
                    tab_req.re    = 1'b1;
                    tab_req.raddr = r_i + 1'b1;
                    n_i           = r_i + 1'b1;
                    n_state       = S_BOX_MN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_verdict   = r_verdict;
    assign o_cfg_ready = 1'b1;

    a_verdict_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == V_OUTSIDE || o_verdict == V_INTERSECT
                     || o_verdict == V_INSIDE))
        else $error("verdict code out of range");

    a_valid_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobed while still busy");

    a_box_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_BOX) |=> (o_busy && !o_valid))
        else $error("box request did not start a run");

    a_no_result_for_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd != CMD_BOX) |=> !o_valid)
        else $error("result given for a non-box request");

endmodule
